// ===== rtl/aitsf_pkg.sv =====
// Shared types and constants for the audio interrupt timebase and sample FIFO.
// No dependencies; every other file in rtl/ except aitsf_ram.sv imports this package.
package aitsf_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int FILL_W     = 14;
  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = 2 * SAMPLE_W;
  localparam int MODE_W     = 2;
  localparam int CYC_W      = 8;
  localparam int CPS_W      = 10;
  localparam int ACC_W      = CPS_W + 1;
  localparam int OWED_W     = 8;
  localparam int BATCH_W    = 13;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELIVER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_SAMPLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWED_LIMIT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_BATCH        = 3'd3;

  localparam logic [CPS_W-1:0]   CPS_RESET        = 10'd319;
  localparam logic [OWED_W-1:0]  OWED_LIMIT_RESET = 8'd64;
  localparam logic [BATCH_W-1:0] MAX_BATCH_RESET  = 13'd2048;
  localparam logic [BATCH_W-1:0] IDLE_BATCH_RESET = 13'd692;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [CYC_W-1:0]           cycles;
    logic                       in_cartridge;
    logic                       i2s_enabled;
    logic                       irq_masked;
    logic                       dsp_accepts;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } item_t;

  typedef struct packed {
    logic                       irq_fired;
    logic [OWED_W-1:0]          owed_now;
    logic [BATCH_W-1:0]         batch_count;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [FILL_W-1:0]          fill_level;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sub_step;
    logic adv_done;
    logic deliver;
    logic frame;
    logic pull_rd;
    logic pull_take;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_ge;
    logic ring_nonempty;
  } dp_stat_t;

endpackage

// ===== rtl/aitsf_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on aitsf_pkg for field widths.
interface aitsf_in_if;
  import aitsf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [CYC_W-1:0]           cycles;
  logic                       in_cartridge;
  logic                       i2s_enabled;
  logic                       irq_masked;
  logic                       dsp_accepts;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (
    output valid, mode, cycles, in_cartridge, i2s_enabled, irq_masked, dsp_accepts,
           left_sample, right_sample,
    input  ready
  );
  modport sink (
    input  valid, mode, cycles, in_cartridge, i2s_enabled, irq_masked, dsp_accepts,
           left_sample, right_sample,
    output ready
  );
endinterface

interface aitsf_out_if;
  import aitsf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       irq_fired;
  logic [OWED_W-1:0]          owed_now;
  logic [BATCH_W-1:0]         batch_count;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [FILL_W-1:0]          fill_level;

  modport source (
    output valid, irq_fired, owed_now, batch_count, left_out, right_out, fill_level,
    input  ready
  );
  modport sink (
    input  valid, irq_fired, owed_now, batch_count, left_out, right_out, fill_level,
    output ready
  );
endinterface

// ===== rtl/audio_irq_timebase_and_sample_fifo.sv =====
// Audio sample-clock timebase and stereo sample FIFO, one result item per input item.
// An item is taken only when the previous one has finished its steps; a finished result
// may still wait in the output register while the next item is taken. An advance item
// removes n whole sample periods from the accumulator: the period subtractor removes
// one per cycle, so n is usually 0 or 1 and reaches 1277 only with a period setting
// of 0 or 1. A pull item passes through a wait state for the ring RAM's registered
// read when the ring holds a pair and skips it when the ring is empty. The ring needs
// no clearing pass after reset. Configuration writes are taken at any edge with
// cfg_we high and rst low; indexes past the last register are ignored.
module audio_irq_timebase_and_sample_fifo (
  input  logic                             clk,
  input  logic                             rst,
  aitsf_in_if.sink                         cmd,
  aitsf_out_if.source                      res,
  input  logic                             cfg_we,
  input  logic [aitsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aitsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aitsf_pkg::*;

  item_t    item;
  result_t  result;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  logic     out_valid;

  assign item.mode         = cmd.mode;
  assign item.cycles       = cmd.cycles;
  assign item.in_cartridge = cmd.in_cartridge;
  assign item.i2s_enabled  = cmd.i2s_enabled;
  assign item.irq_masked   = cmd.irq_masked;
  assign item.dsp_accepts  = cmd.dsp_accepts;
  assign item.left_sample  = cmd.left_sample;
  assign item.right_sample = cmd.right_sample;
  assign cmd.ready         = in_ready;

  assign res.valid       = out_valid;
  assign res.irq_fired   = result.irq_fired;
  assign res.owed_now    = result.owed_now;
  assign res.batch_count = result.batch_count;
  assign res.left_out    = result.left_out;
  assign res.right_out   = result.right_out;
  assign res.fill_level  = result.fill_level;

  aitsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_mode   (cmd.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (res.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  aitsf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .result    (result)
  );

endmodule

// ===== rtl/aitsf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aitsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aitsf_ctrl.sv =====
// Controller state machine: accepts items, sequences datapath steps, owns result valid.
// Depends on aitsf_pkg.
module aitsf_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [aitsf_pkg::MODE_W-1:0] in_mode,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  aitsf_pkg::dp_stat_t          stat,
  output aitsf_pkg::dp_cmd_t           cmd
);
  import aitsf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADV   = 3'd1;
  localparam logic [2:0] S_DLV   = 3'd2;
  localparam logic [2:0] S_FRM   = 3'd3;
  localparam logic [2:0] S_PULL  = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_mode)
            MODE_ADVANCE: state_next = S_ADV;
            MODE_DELIVER: state_next = S_DLV;
            MODE_FRAME:   state_next = S_FRM;
            MODE_PULL:    state_next = S_PULL;
            default:      state_next = S_PULL;
          endcase
        end
      end
      S_ADV: begin
        // take out one whole sample period per cycle
        if (stat.acc_ge) begin
          cmd.sub_step = 1'b1;
        end else begin
          cmd.adv_done = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_DLV: begin
        cmd.deliver = 1'b1;
        state_next  = S_FIN;
      end
      S_FRM: begin
        cmd.frame  = 1'b1;
        state_next = S_FIN;
      end
      S_PULL: begin
        cmd.pull_rd = 1'b1;
        state_next  = stat.ring_nonempty ? S_PWAIT : S_FIN;
      end
      S_PWAIT: begin
        cmd.pull_take = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/aitsf_dp.sv =====
// Datapath: configuration registers, timebase counters, ring pointers, held pair
// and result register. Depends on aitsf_pkg and aitsf_ram.
module aitsf_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [aitsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aitsf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  aitsf_pkg::item_t                 item,
  input  aitsf_pkg::dp_cmd_t               cmd,
  output aitsf_pkg::dp_stat_t              stat,
  output aitsf_pkg::result_t               result
);
  import aitsf_pkg::*;

  logic [CPS_W-1:0]   cycles_per_sample;
  logic [OWED_W-1:0]  owed_limit;
  logic [BATCH_W-1:0] max_batch;
  logic [BATCH_W-1:0] idle_batch;

  item_t              item_r;
  logic               launched;
  logic [ACC_W-1:0]   acc;
  logic [CPS_W-1:0]   cycle_accum;
  logic [OWED_W-1:0]  owed_count;
  logic [TICK_W-1:0]  frame_ticks;
  logic [PTR_W-1:0]   write_ptr;
  logic [PTR_W-1:0]   read_ptr;
  logic [CNT_W-1:0]   pair_count;
  logic [PAIR_W-1:0]  held_pair;
  logic               fired;
  logic [BATCH_W-1:0] batch;

  logic [CPS_W-1:0]   period;
  logic               fire_ok;
  logic               ring_full;
  logic               ram_we;
  logic               ram_re;
  logic [PAIR_W-1:0]  ram_rdata;
  logic [BATCH_W-1:0] batch_clamp;
  logic [BATCH_W-1:0] batch_calc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_sample <= CPS_RESET;
      owed_limit        <= OWED_LIMIT_RESET;
      max_batch         <= MAX_BATCH_RESET;
      idle_batch        <= IDLE_BATCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CYCLES_PER_SAMPLE: cycles_per_sample <= cfg_data[CPS_W-1:0];
        REG_OWED_LIMIT:        owed_limit        <= cfg_data[OWED_W-1:0];
        REG_MAX_BATCH:         max_batch         <= cfg_data[BATCH_W-1:0];
        REG_IDLE_BATCH:        idle_batch        <= cfg_data[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero period setting is treated as 1
  assign period    = (cycles_per_sample == '0) ? CPS_W'(1) : cycles_per_sample;
  assign fire_ok   = launched && (owed_count != '0) && item_r.i2s_enabled &&
                     !item_r.irq_masked && item_r.dsp_accepts;
  assign ring_full = (pair_count == CNT_W'(RING_DEPTH));
  assign ram_we    = cmd.deliver && fire_ok && !ring_full;
  assign ram_re    = cmd.pull_rd && (pair_count != '0);

  assign batch_clamp = (frame_ticks > TICK_W'(max_batch)) ? max_batch
                                                          : frame_ticks[BATCH_W-1:0];
  assign batch_calc  = (batch_clamp == '0) ? idle_batch : batch_clamp;

  assign stat.acc_ge        = (acc >= ACC_W'(period));
  assign stat.ring_nonempty = (pair_count != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
      acc    <= ACC_W'(cycle_accum) + ACC_W'(item.cycles);
    end else if (cmd.sub_step) begin
      acc <= acc - ACC_W'(period);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched    <= 1'b0;
      cycle_accum <= '0;
      owed_count  <= '0;
      frame_ticks <= '0;
      write_ptr   <= '0;
      read_ptr    <= '0;
      pair_count  <= '0;
      held_pair   <= '0;
      fired       <= 1'b0;
      batch       <= '0;
    end else begin
      if (cmd.load) begin
        // latch launch before the item acts
        launched <= launched | item.in_cartridge;
        fired    <= 1'b0;
        batch    <= '0;
      end
      if (cmd.adv_done) begin
        cycle_accum <= acc[CPS_W-1:0];
      end
      if (cmd.sub_step) begin
        if (owed_count < owed_limit) begin
          owed_count <= owed_count + OWED_W'(1);
        end
        if (frame_ticks != '1) begin
          frame_ticks <= frame_ticks + TICK_W'(1);
        end
      end
      if (cmd.deliver && fire_ok) begin
        // a full ring drops the pair but still spends the interrupt
        owed_count <= owed_count - OWED_W'(1);
        fired      <= 1'b1;
      end
      if (ram_we) begin
        write_ptr <= ptr_inc(write_ptr);
      end
      if (cmd.frame) begin
        batch       <= batch_calc;
        frame_ticks <= '0;
      end
      if (ram_re) begin
        read_ptr <= ptr_inc(read_ptr);
      end
      if (ram_we && !ram_re) begin
        pair_count <= pair_count + CNT_W'(1);
      end else if (ram_re && !ram_we) begin
        pair_count <= pair_count - CNT_W'(1);
      end
      if (cmd.pull_take) begin
        held_pair <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.irq_fired   <= fired;
      result.owed_now    <= owed_count;
      result.batch_count <= batch;
      result.left_out    <= held_pair[SAMPLE_W-1:0];
      result.right_out   <= held_pair[PAIR_W-1:SAMPLE_W];
      result.fill_level  <= FILL_W'(pair_count);
    end
  end

  aitsf_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata ({item_r.right_sample, item_r.left_sample}),
    .re    (ram_re),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/aitsf_checker.sv =====
// Port-level checks for the audio timebase and sample FIFO, bound to the top level.
// Depends on aitsf_pkg and audio_irq_timebase_and_sample_fifo.
module aitsf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               irq_fired,
  input logic [aitsf_pkg::BATCH_W-1:0]      batch_count,
  input logic [aitsf_pkg::FILL_W-1:0]       fill_level,
  input logic [aitsf_pkg::OWED_W-1:0]       owed_now
);
  import aitsf_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fill_level) && $stable(owed_now))
    else $error("stalled result changed");

  // one item in the works at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken in the cycle after an accept");

  a_fire_no_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_fired |-> batch_count == '0)
    else $error("fired interrupt with a batch count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= FILL_W'(RING_DEPTH))
    else $error("fill level beyond ring depth");

endmodule

bind audio_irq_timebase_and_sample_fifo aitsf_checker u_aitsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (cmd.valid),
  .in_ready    (cmd.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .irq_fired   (res.irq_fired),
  .batch_count (res.batch_count),
  .fill_level  (res.fill_level),
  .owed_now    (res.owed_now)
);
